// File: sv/kos_pkg.sv
// ----------------------------------------------------------------------------
// Kepler orbit state solver package
// Register indexes, reset values, fixed-point constants and the CORDIC
// arctangent table in turns scaled by 2^32.
// ----------------------------------------------------------------------------
package kos_pkg;

  localparam int CORDIC_STEPS_DEF = 32;
  localparam int ATAN_LEN         = 48;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ECC   = 3'd0;
  localparam logic [2:0] REG_TOL   = 3'd1;
  localparam logic [2:0] REG_MAXIT = 3'd2;
  localparam logic [2:0] REG_HAF   = 3'd3;
  localparam logic [2:0] REG_SLR   = 3'd4;
  localparam logic [2:0] REG_SPD   = 3'd5;

  localparam logic [31:0] ECC_RST   = 32'd2820492177;
  localparam logic [15:0] TOL_RST   = 16'd6836;
  localparam logic [7:0]  MAXIT_RST = 8'd64;
  localparam logic [31:0] HAF_RST   = 32'd589699010;
  localparam logic [31:0] SLR_RST   = 32'd4373680;
  localparam logic [31:0] SPD_RST   = 32'd147972424;

  localparam logic signed [37:0] GAIN_Q30       = 38'sd652032874;
  localparam logic [31:0]        ONE_Q30        = 32'h4000_0000;
  localparam logic [31:0]        INV_TWO_PI_Q32 = 32'd683565276;

  function automatic logic [29:0] atan_turns(input logic [5:0] i);
    case (i)
      6'd0:  return 30'd536870912;
      6'd1:  return 30'd316933406;
      6'd2:  return 30'd167458907;
      6'd3:  return 30'd85004756;
      6'd4:  return 30'd42667331;
      6'd5:  return 30'd21354465;
      6'd6:  return 30'd10679838;
      6'd7:  return 30'd5340245;
      6'd8:  return 30'd2670163;
      6'd9:  return 30'd1335087;
      6'd10: return 30'd667544;
      6'd11: return 30'd333772;
      6'd12: return 30'd166886;
      6'd13: return 30'd83443;
      6'd14: return 30'd41722;
      6'd15: return 30'd20861;
      6'd16: return 30'd10430;
      6'd17: return 30'd5215;
      6'd18: return 30'd2608;
      6'd19: return 30'd1304;
      6'd20: return 30'd652;
      6'd21: return 30'd326;
      6'd22: return 30'd163;
      6'd23: return 30'd81;
      6'd24: return 30'd41;
      6'd25: return 30'd20;
      6'd26: return 30'd10;
      6'd27: return 30'd5;
      6'd28: return 30'd3;
      6'd29: return 30'd1;
      6'd30: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

endpackage

// File: sv/kos_ifs.sv
// ----------------------------------------------------------------------------
// Kepler orbit state solver channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kos_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean_anomaly;
  modport source (output valid, output mean_anomaly, input ready);
  modport sink   (input valid, input mean_anomaly, output ready);
endinterface

interface kos_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        true_anomaly;
  logic [31:0]        radius;
  logic signed [31:0] radial_speed;
  logic [30:0]        transverse_speed;
  logic [30:0]        total_speed;
  logic               not_converged;
  modport source (output valid, output true_anomaly, output radius, output radial_speed,
                  output transverse_speed, output total_speed, output not_converged,
                  input ready);
  modport sink   (input valid, input true_anomaly, input radius, input radial_speed,
                  input transverse_speed, input total_speed, input not_converged,
                  output ready);
endinterface

interface kos_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/kepler_orbit_state_solver.sv
// ----------------------------------------------------------------------------
// Kepler orbit state solver
// Solves E = M + e*sin(E) by fixed-point iteration on a shared CORDIC, then
// derives true anomaly, radius and speeds with one shared multiplier, a
// restoring divider and a bit-serial square root.
// ----------------------------------------------------------------------------
// channel  dir  word
// req      in   mean_anomaly
// rsp      out  true_anomaly, radius, radial_speed, transverse_speed,
//               total_speed, not_converged
// cfg      in   index, data (always ready)
//
// One word at a time. The CORDIC loop, one step a cycle, runs once per Kepler
// update and three times more, and then come 62 divider and 32 square root
// steps.
// The response register frees req as soon as a result is loaded.
// Reset (rst, synchronous) restores the registers and empties the block.
// ----------------------------------------------------------------------------
module kepler_orbit_state_solver #(
  parameter int CORDIC_STEPS = kos_pkg::CORDIC_STEPS_DEF
) (
  input logic         clk,
  input logic         rst,
  kos_req_if.sink     req,
  kos_rsp_if.source   rsp,
  kos_cfg_if.sink     cfg
);

  localparam int NSTEP = (CORDIC_STEPS < kos_pkg::ATAN_LEN) ? CORDIC_STEPS : kos_pkg::ATAN_LEN;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_ROT  = 19'h00002, S_ROTF = 19'h00004, S_KM1  = 19'h00008,
    S_KM2  = 19'h00010, S_KCHK = 19'h00020, S_YM   = 19'h00040, S_VST  = 19'h00080,
    S_EC   = 19'h00100, S_ES   = 19'h00200, S_RM   = 19'h00400, S_TM   = 19'h00800,
    S_DVS  = 19'h01000, S_DIV  = 19'h02000, S_SQ1  = 19'h04000, S_SQ2  = 19'h08000,
    S_SQ3  = 19'h10000, S_SQRT = 19'h20000, S_DONE = 19'h40000
  } state_t;

  typedef enum logic [1:0] {PH_KEP, PH_HALF, PH_VEC, PH_TRUE} phase_t;

  state_t state, state_next;
  phase_t phase, rot_phase;

  // configuration
  logic [31:0] ecc, haf, slr, spd;
  logic [15:0] tol;
  logic [7:0]  maxit;

  // CORDIC
  logic signed [37:0] cx, cy, dx, dy;
  logic signed [33:0] cz, da;
  logic               cflip, cvec, dpos;
  logic [5:0]         cnt;
  logic               rot_start, rot_fold;
  logic [31:0]        rot_ang, rot_a;

  // datapath
  logic [31:0]        mean, est, cur, term, dd, dm, anom, den, rmag;
  logic [7:0]         it;
  logic               conv, stop, nc, esneg;
  logic signed [31:0] sn, cs;
  logic [31:0]        sn_abs, cs_abs, mul_a, mul_b;
  logic [63:0]        prod;
  logic [34:0]        yfm;
  logic signed [37:0] x0, y0;
  logic [33:0]        rp, tp;
  logic [30:0]        tmag;
  logic [31:0]        rem;
  logic [32:0]        dt;
  logic               dge;
  logic [61:0]        num;
  logic [63:0]        sv, res, bitv, rb;

  function automatic logic signed [31:0] clamp30(input logic signed [37:0] v);
    if (v > 38'sd1073741824) return 32'sd1073741824;
    if (v < -38'sd1073741824) return -32'sd1073741824;
    return v[31:0];
  endfunction

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ecc   <= kos_pkg::ECC_RST;
      tol   <= kos_pkg::TOL_RST;
      maxit <= kos_pkg::MAXIT_RST;
      haf   <= kos_pkg::HAF_RST;
      slr   <= kos_pkg::SLR_RST;
      spd   <= kos_pkg::SPD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        kos_pkg::REG_ECC:   ecc   <= cfg.data;
        kos_pkg::REG_TOL:   tol   <= cfg.data[15:0];
        kos_pkg::REG_MAXIT: maxit <= cfg.data[7:0];
        kos_pkg::REG_HAF:   haf   <= cfg.data;
        kos_pkg::REG_SLR:   slr   <= cfg.data;
        kos_pkg::REG_SPD:   spd   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  // iteration check
  assign sn_abs = sn[31] ? 32'(-sn) : 32'(sn);
  assign cs_abs = cs[31] ? 32'(-cs) : 32'(cs);
  assign term   = prod[61:30];
  assign cur    = sn[31] ? mean - term : mean + term;
  assign dd     = cur - est;
  assign dm     = dd[31] ? 32'd0 - dd : dd;
  assign conv   = dm < {16'd0, tol};
  assign stop   = conv || (it >= maxit);

  // rotation start: angle folded into the right half plane
  always_comb begin
    rot_start = 1'b0;
    rot_ang   = est;
    rot_phase = PH_KEP;
    case (state)
      S_IDLE: begin
        rot_start = req.valid;
        rot_ang   = req.mean_anomaly;
      end
      S_KCHK: begin
        rot_start = 1'b1;
        rot_ang   = stop ? {1'b0, cur[31:1]} : cur;
        rot_phase = stop ? PH_HALF : PH_KEP;
      end
      S_ROTF: begin
        rot_start = (phase == PH_VEC);
        rot_ang   = {cz[30:0], 1'b0};
        rot_phase = PH_TRUE;
      end
      default: ;
    endcase
  end
  assign rot_fold = rot_ang[31] ^ rot_ang[30];
  assign rot_a    = rot_fold ? rot_ang + 32'h8000_0000 : rot_ang;

  assign dx   = cy >>> cnt;
  assign dy   = cx >>> cnt;
  assign da   = $signed({4'd0, kos_pkg::atan_turns(cnt)});
  assign dpos = cvec ? cy[37] : !cz[33];

  // vectoring start from cos(h) and the scaled sin(h)
  assign yfm = prod[62:28];
  assign x0  = {{6{cs[31]}}, cs};
  assign y0  = sn[31] ? -$signed({3'd0, yfm}) : $signed({3'd0, yfm});

  always_ff @(posedge clk) begin
    if (rot_start) begin
      cx    <= kos_pkg::GAIN_Q30;
      cy    <= '0;
      cz    <= $signed({{2{rot_a[31]}}, rot_a});
      cflip <= rot_fold;
      cvec  <= 1'b0;
      phase <= rot_phase;
    end else if (state == S_VST) begin
      cx    <= cs[31] ? -x0 : x0;
      cy    <= cs[31] ? -y0 : y0;
      cz    <= cs[31] ? 34'sh0_8000_0000 : 34'sd0;
      cflip <= 1'b0;
      cvec  <= 1'b1;
      phase <= PH_VEC;
    end else if (state == S_ROT) begin
      if (dpos) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - da;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rot_start || state == S_VST || state == S_DVS || state == S_SQ3) begin
      cnt <= '0;
    end else if (state == S_ROT || state == S_DIV || state == S_SQRT) begin
      cnt <= cnt + 6'd1;
    end
  end

  // shared multiplier, product registered every cycle
  always_comb begin
    mul_a = sn_abs;
    mul_b = ecc;
    case (state)
      S_KM2: begin mul_a = prod[63:32]; mul_b = kos_pkg::INV_TWO_PI_Q32; end
      S_YM:  begin mul_a = sn_abs;      mul_b = haf;                     end
      S_EC:  begin mul_a = cs_abs;      mul_b = ecc;                     end
      S_RM:  begin mul_a = prod[63:32]; mul_b = spd;                     end
      S_TM:  begin mul_a = spd;         mul_b = den;                     end
      S_SQ1: begin mul_a = rmag;        mul_b = rmag;                    end
      S_SQ2: begin mul_a = {1'b0, tmag}; mul_b = {1'b0, tmag};           end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  assign rp  = prod[63:30];
  assign tp  = prod[63:30];
  assign dt  = {rem, num[61]};
  assign dge = dt >= {1'b0, den};
  assign rb  = res + bitv;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          mean <= req.mean_anomaly;
          est  <= req.mean_anomaly;
          it   <= '0;
        end
      end
      S_ROTF: begin
        sn <= clamp30(cflip ? -cy : cy);
        cs <= clamp30(cflip ? -cx : cx);
        if (phase == PH_VEC) begin
          anom <= {cz[30:0], 1'b0};
        end
      end
      S_KCHK: begin
        nc <= !conv;
        if (!stop) begin
          est <= cur;
          it  <= it + 8'd1;
        end
      end
      S_ES: begin
        den <= cs[31] ? kos_pkg::ONE_Q30 - prod[63:32] : kos_pkg::ONE_Q30 + prod[63:32];
      end
      S_RM: begin
        esneg <= sn[31];
      end
      S_TM: begin
        if (esneg) begin
          rmag <= (rp > 34'h0_8000_0000) ? 32'h8000_0000 : rp[31:0];
        end else begin
          rmag <= (rp > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rp[31:0];
        end
      end
      S_DVS: begin
        tmag <= (tp > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : tp[30:0];
        num  <= {slr, 30'd0};
        rem  <= '0;
      end
      S_DIV: begin
        rem <= dge ? 32'(dt - {1'b0, den}) : dt[31:0];
        num <= {num[60:0], dge};
      end
      S_SQ2: begin
        sv <= prod;
      end
      S_SQ3: begin
        sv   <= sv + prod;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (sv >= rb) begin
          sv  <= sv - rb;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) state_next = S_ROT;
      S_ROT:  if (cnt == 6'(NSTEP - 1)) state_next = S_ROTF;
      S_ROTF: begin
        case (phase)
          PH_KEP:  state_next = S_KM1;
          PH_HALF: state_next = S_YM;
          PH_VEC:  state_next = S_ROT;
          PH_TRUE: state_next = S_EC;
          default: state_next = S_IDLE;
        endcase
      end
      S_KM1:  state_next = S_KM2;
      S_KM2:  state_next = S_KCHK;
      S_KCHK: state_next = S_ROT;
      S_YM:   state_next = S_VST;
      S_VST:  state_next = S_ROT;
      S_EC:   state_next = S_ES;
      S_ES:   state_next = S_RM;
      S_RM:   state_next = S_TM;
      S_TM:   state_next = S_DVS;
      S_DVS:  state_next = S_DIV;
      S_DIV:  if (cnt == 6'd61) state_next = S_SQ1;
      S_SQ1:  state_next = S_SQ2;
      S_SQ2:  state_next = S_SQ3;
      S_SQ3:  state_next = S_SQRT;
      S_SQRT: if (cnt == 6'd31) state_next = S_DONE;
      S_DONE: if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.true_anomaly     <= anom;
      rsp.radius           <= (|num[61:32]) ? 32'hFFFF_FFFF : num[31:0];
      rsp.radial_speed     <= esneg ? $signed(32'd0 - rmag) : $signed(rmag);
      rsp.transverse_speed <= tmag;
      rsp.total_speed      <= (res > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : res[30:0];
      rsp.not_converged    <= nc;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while an item is in flight");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != 32'd0))
    else $error("divider started with zero denominator");

  a_cordic_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (cnt < 6'(NSTEP)))
    else $error("CORDIC step index out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("response raised outside the completion state");
`endif

endmodule

// File: tb/kepler_orbit_state_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kepler orbit state solver testbench
// Drives mean anomalies through the solver under several register settings
// and checks every result word against a bit-true predictor.
// The run has a directed table, then random words. Both sides idle at random,
// and there is one long receiver hold-off and one sender drain pause.
// ----------------------------------------------------------------------------
module kepler_orbit_state_solver_tb;

  typedef struct packed {
    logic [31:0] true_anomaly;
    logic [31:0] radius;
    logic [31:0] radial_speed;
    logic [30:0] transverse_speed;
    logic [30:0] total_speed;
    logic        not_converged;
  } orbit_state_t;

  typedef struct {
    logic [31:0]  mean;
    bit           known;
    orbit_state_t state;
  } stim_row_t;

  localparam int  NUM_RANDOM  = 500;
  localparam int  SETTLE      = 400;
  localparam int  HOLD_AT     = 140;
  localparam int  HOLD_CYCLES = 20000;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kos_req_if req ();
  kos_rsp_if rsp ();
  kos_cfg_if cfg ();

  kepler_orbit_state_solver DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies held by the predictor
  logic [31:0] ecc_q;
  logic [15:0] tol_q;
  logic [7:0]  maxit_q;
  logic [31:0] haf_q;
  logic [31:0] slr_q;
  logic [31:0] spd_q;

  orbit_state_t expected_states[$];
  int     mismatches = 0;
  longint cycles     = 0;

  function automatic longint atan_at(int i);
    longint v;
    v = (i < kos_pkg::ATAN_LEN) ? longint'(kos_pkg::atan_turns(i[5:0])) : 0;
    return v;
  endfunction

  // arithmetic shift right rounds toward minus infinity
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint scale_by_ecc(logic [31:0] frac, longint v);
    longint unsigned m;
    longint r;
    m = (v < 0) ? -v : v;
    r = longint'((m * frac) >> 32);
    return (v < 0) ? -r : r;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint sn, output longint cs);
    logic [31:0] a;
    logic [31:0] t;
    bit     flip;
    longint x, y, z, dx, dy;
    a = ang;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    t = a + 32'h4000_0000;
    if (t[31]) begin
      a = a + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < kos_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_at(i);
      end else begin
        x += dx; y -= dy; z += atan_at(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = clamp_unit(y);
    cs = clamp_unit(x);
  endtask

  function automatic logic [31:0] vector_angle(longint xi, longint yi);
    longint x, y, dx, dy;
    logic [31:0] z;
    x = xi; y = yi; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < kos_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z = z + 32'(atan_at(i));
      end else begin
        x -= dx; y += dy; z = z - 32'(atan_at(i));
      end
    end
    return z;
  endfunction

  task automatic anomaly_update(input logic [31:0] mean, input logic [31:0] est,
                                output logic [31:0] nxt);
    longint s, c, es;
    longint unsigned m;
    logic [31:0] term;
    rotate(est, s, c);
    es = scale_by_ecc(ecc_q, s);
    m = (es < 0) ? -es : es;
    term = 32'((m * 64'd683565276) >> 30);
    nxt = (es < 0) ? mean - term : mean + term;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic solve_orbit(input logic [31:0] mean, output orbit_state_t o);
    logic [31:0] prev, cur, d, dm, phi, anom;
    int     count;
    bit     nc;
    longint sh, ch, yf, st, ct, ec, es, den;
    longint unsigned m, rad, rmag, tmag, tot;
    prev = mean;
    count = 0;
    nc = 1'b0;
    anomaly_update(mean, mean, cur);
    forever begin
      d = cur - prev;
      dm = d[31] ? -d : d;
      if (dm < tol_q) break;
      if (count >= maxit_q) begin
        nc = 1'b1;
        break;
      end
      prev = cur;
      anomaly_update(mean, prev, cur);
      count++;
    end
    rotate(cur >> 1, sh, ch);
    m = (sh < 0) ? -sh : sh;
    yf = longint'((m * haf_q) >> 28);
    if (sh < 0) yf = -yf;
    phi = vector_angle(ch, yf);
    anom = phi << 1;
    rotate(anom, st, ct);
    ec = scale_by_ecc(ecc_q, ct);
    den = 64'sd1073741824 + ec;
    es = scale_by_ecc(ecc_q, st);
    rad = ({32'd0, slr_q} << 30) / longint'(den);
    if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
    m = (es < 0) ? -es : es;
    rmag = (m * spd_q) >> 30;
    if (es < 0) begin
      if (rmag > 64'h8000_0000) rmag = 64'h8000_0000;
    end else if (rmag > 64'h7FFF_FFFF) begin
      rmag = 64'h7FFF_FFFF;
    end
    tmag = (longint'(spd_q) * den) >> 30;
    if (tmag > 64'h7FFF_FFFF) tmag = 64'h7FFF_FFFF;
    tot = int_sqrt(rmag * rmag + tmag * tmag);
    if (tot > 64'h7FFF_FFFF) tot = 64'h7FFF_FFFF;
    o.true_anomaly     = anom;
    o.radius           = rad[31:0];
    o.radial_speed     = (es < 0) ? 32'(-rmag) : rmag[31:0];
    o.transverse_speed = tmag[30:0];
    o.total_speed      = tot[30:0];
    o.not_converged    = nc;
  endtask

  // cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // response side: random stalls, one long hold-off, checking
  initial begin
    int gap;
    int n_rcv;
    orbit_state_t exp_s, got;
    n_rcv = 0;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      rsp.ready = 1'b0;
      repeat (gap) @(negedge clk);
      // hold off once while the sender keeps offering words
      if (n_rcv == HOLD_AT) repeat (HOLD_CYCLES) @(negedge clk);
      rsp.ready = 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got.true_anomaly     = rsp.true_anomaly;
      got.radius           = rsp.radius;
      got.radial_speed     = rsp.radial_speed;
      got.transverse_speed = rsp.transverse_speed;
      got.total_speed      = rsp.total_speed;
      got.not_converged    = rsp.not_converged;
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        exp_s = expected_states.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %p actual %p", exp_s, got);
        end
      end
      n_rcv++;
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
    case (idx)
      kos_pkg::REG_ECC:   ecc_q   = val;
      kos_pkg::REG_TOL:   tol_q   = val[15:0];
      kos_pkg::REG_MAXIT: maxit_q = val[7:0];
      kos_pkg::REG_HAF:   haf_q   = val;
      kos_pkg::REG_SLR:   slr_q   = val;
      default:            spd_q   = val;
    endcase
  endtask

  task automatic send_mean(input logic [31:0] mean, input bit known,
                           input orbit_state_t typed, input bit no_gap);
    orbit_state_t o;
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
    repeat (gap) @(negedge clk);
    req.valid = 1'b1;
    req.mean_anomaly = mean;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    solve_orbit(mean, o);
    if (known && o !== typed) begin
      mismatches++;
      if (mismatches <= 10) $display("table row %h disagrees with predictor", mean);
    end
    expected_states.push_back(known ? typed : o);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_states.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // a setting per phase: ecc, tol, maxit, haf, slr, spd
  task automatic load_setting(input int k);
    case (k)
      0: begin
        write_reg(kos_pkg::REG_ECC, 32'd0); write_reg(kos_pkg::REG_TOL, 32'd0);
        write_reg(kos_pkg::REG_MAXIT, 32'd1); write_reg(kos_pkg::REG_HAF, 32'h1000_0000);
        write_reg(kos_pkg::REG_SLR, 32'hFFFF_FFFF);
        write_reg(kos_pkg::REG_SPD, 32'hFFFF_FFFF);
      end
      1: begin
        write_reg(kos_pkg::REG_ECC, 32'hFFFF_FFFF); write_reg(kos_pkg::REG_TOL, 32'hFFFF);
        write_reg(kos_pkg::REG_MAXIT, 32'd255); write_reg(kos_pkg::REG_HAF, 32'hFFFF_FFFF);
        write_reg(kos_pkg::REG_SLR, 32'd0); write_reg(kos_pkg::REG_SPD, 32'd0);
      end
      2: begin
        write_reg(kos_pkg::REG_ECC, 32'h4000_0000); write_reg(kos_pkg::REG_TOL, 32'd100);
        write_reg(kos_pkg::REG_MAXIT, 32'd0); write_reg(kos_pkg::REG_HAF, 32'd0);
        write_reg(kos_pkg::REG_SLR, 32'd7690000);
        write_reg(kos_pkg::REG_SPD, 32'd147972424);
      end
      default: begin
        write_reg(kos_pkg::REG_ECC, $urandom);
        write_reg(kos_pkg::REG_TOL, $urandom_range(0, 65535));
        write_reg(kos_pkg::REG_MAXIT, $urandom_range(1, 20));
        write_reg(kos_pkg::REG_HAF, $urandom);
        write_reg(kos_pkg::REG_SLR, $urandom); write_reg(kos_pkg::REG_SPD, $urandom);
      end
    endcase
  endtask

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    orbit_state_t zero_s;
    logic [31:0] m;
    req.valid = 1'b0;
    req.mean_anomaly = '0;
    cfg.valid = 1'b0;
    cfg.index = kos_pkg::REG_ECC;
    cfg.data  = '0;
    ecc_q = kos_pkg::ECC_RST; tol_q = kos_pkg::TOL_RST; maxit_q = kos_pkg::MAXIT_RST;
    haf_q = kos_pkg::HAF_RST; slr_q = kos_pkg::SLR_RST; spd_q = kos_pkg::SPD_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table under reset settings: quadrant edges and wrap points
    zero_s = '0;
    row.known = 1'b0; row.state = zero_s;
    for (int i = 0; i < 10; i++) begin
      case (i)
        0: m = 32'h0000_0000; 1: m = 32'hFFFF_FFFF; 2: m = 32'h8000_0000;
        3: m = 32'h7FFF_FFFF; 4: m = 32'h4000_0000; 5: m = 32'hC000_0000;
        6: m = 32'h0000_0001; 7: m = 32'h5555_5555; 8: m = 32'hAAAA_AAAA;
        default: m = 32'h8000_0001;
      endcase
      row.mean = m;
      table_rows.push_back(row);
    end
    foreach (table_rows[i]) send_mean(table_rows[i].mean, table_rows[i].known,
                                      table_rows[i].state, 1'b0);
    drain();

    // extreme settings, a few words each: zero ecc, ecc near one, zero limit
    for (int k = 0; k < 3; k++) begin
      load_setting(k);
      foreach (table_rows[i])
        if (i < 5) send_mean(table_rows[i].mean, 1'b0, zero_s, 1'b0);
      drain();
    end

    // random phases; the first at reset values, the rest under random settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(kos_pkg::REG_ECC, kos_pkg::ECC_RST);
        write_reg(kos_pkg::REG_TOL, 32'(kos_pkg::TOL_RST));
        write_reg(kos_pkg::REG_MAXIT, 32'(kos_pkg::MAXIT_RST));
        write_reg(kos_pkg::REG_HAF, kos_pkg::HAF_RST);
        write_reg(kos_pkg::REG_SLR, kos_pkg::SLR_RST);
        write_reg(kos_pkg::REG_SPD, kos_pkg::SPD_RST);
      end else begin
        load_setting(3);
      end
      for (int n = 0; n < NUM_RANDOM / 5; n++) begin
        send_mean($urandom, 1'b0, zero_s, 1'b0);
        // pause until every result is back once
        if (ph == 2 && n == 20) while (expected_states.size() != 0) @(negedge clk);
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
sv/kos_pkg.sv
sv/kos_ifs.sv
sv/kepler_orbit_state_solver.sv
tb/kepler_orbit_state_solver_tb.sv
